[hdl/ppct_pkg.sv]
// ----------------------------------------------------------------------------
// ppct_pkg: shared types and codes for the channel pair table.
// Holds the command and status codes and the beat structs.
// ----------------------------------------------------------------------------
package ppct_pkg;

  typedef enum logic [2:0] {
    CMD_CREATE = 3'd0,
    CMD_RETAIN = 3'd1,
    CMD_CLOSE  = 3'd2,
    CMD_READ   = 3'd3,
    CMD_WRITE  = 3'd4,
    CMD_POLL   = 3'd5,
    CMD_ARM    = 3'd6,
    CMD_CANCEL = 3'd7
  } cmd_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_INVALID = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_BLOCK   = 3'd3;
  localparam logic [2:0] ST_HANGUP  = 3'd4;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [7:0]  slot_index;
    logic        end_side;
    logic [31:0] handle_gen;
    logic [7:0]  data_byte;
    logic [63:0] waiter_id;
    logic        last_in_transfer;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_byte;
    logic [7:0]  new_slot;
    logic [31:0] new_gen;
    logic        readable;
    logic        peer_gone;
    logic        wake_valid;
    logic [63:0] wake_id;
    logic        last_echo;
  } out_beat_t;

  // Back end sequencer states.
  typedef enum logic [1:0] {
    BK_IDLE = 2'd0,
    BK_EXEC = 2'd1,
    BK_RING = 2'd2
  } bk_state_t;

endpackage

[hdl/ppct_ram.sv]
// ----------------------------------------------------------------------------
// ppct_ram: generic single port RAM
// One access per cycle; a write also reads the old data, and the read data is registered.
// ----------------------------------------------------------------------------
module ppct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and read at one address.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[hdl/ppct_front.sv]
// ----------------------------------------------------------------------------
// ppct_front: command intake
// Takes command beats into a two entry queue that feeds the back end.
// ----------------------------------------------------------------------------
module ppct_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ppct_pkg::in_beat_t in_beat,
  output logic               q_valid,
  output ppct_pkg::in_beat_t q_beat,
  input  logic               q_pop
);

  ppct_pkg::in_beat_t ent_r [2];
  logic               rd_ptr_r, rd_ptr_nxt;
  logic               wr_ptr_r, wr_ptr_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic               push;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_beat  = ent_r[rd_ptr_r];

  // Queue pointer and count update.
  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    wr_ptr_nxt = wr_ptr_r ^ push;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_beat;
    end
  end

endmodule

[hdl/ppct_back.sv]
// ----------------------------------------------------------------------------
// ppct_back: command execution
// Checks handles, updates the pair table and runs the ring memory access.
// ----------------------------------------------------------------------------
module ppct_back #(
  parameter int PAIRS      = 8,
  parameter int RING_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  ppct_pkg::in_beat_t  q_beat,
  output logic                q_pop,
  output logic                out_strobe,
  output ppct_pkg::out_beat_t out_beat
);

  localparam int SIDES = 2 * PAIRS;
  localparam int SW    = $clog2(SIDES);
  localparam int PW    = (PAIRS > 1) ? $clog2(PAIRS) : 1;
  localparam int RW    = $clog2(RING_DEPTH);
  localparam int FW    = RW + 1;
  localparam int AW    = $clog2(SIDES * RING_DEPTH);

  logic              in_use_r  [PAIRS];
  logic [31:0]       gen_r     [PAIRS];
  logic [31:0]       ref_r     [SIDES];
  logic [63:0]       waiter_r  [SIDES];
  logic [RW-1:0]     head_r    [SIDES];
  logic [RW-1:0]     tail_r    [SIDES];
  logic [FW-1:0]     fill_r    [SIDES];

  ppct_pkg::bk_state_t state_r, state_nxt;
  ppct_pkg::in_beat_t  cur_r;
  ppct_pkg::out_beat_t res_r, res_nxt;
  logic                strobe_r, strobe_nxt;

  // Ring memory port.
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_rdata;

  ppct_ram #(.WIDTH(8), .DEPTH(SIDES * RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (cur_r.data_byte),
    .rdata (ram_rdata)
  );

  // Handle decode.
  logic          slot_ok;
  logic [PW-1:0] slot;
  logic [SW-1:0] own, peer;
  logic          h_ok;
  logic          free_found;
  logic [PW-1:0] free_slot;
  logic [31:0]   gen_inc;

  always_comb begin
    slot_ok = ({1'b0, cur_r.slot_index} < 9'(PAIRS));
    slot    = PW'(cur_r.slot_index);
    own     = SW'({slot, 1'b0}) | SW'(cur_r.end_side);
    peer    = own ^ SW'(1);
    h_ok    = slot_ok && (cur_r.handle_gen != 32'd0) && in_use_r[slot] &&
              (gen_r[slot] == cur_r.handle_gen) && (ref_r[own] != 32'd0);
    free_found = 1'b0;
    free_slot  = '0;
    for (int i = PAIRS - 1; i >= 0; i--) begin
      if (!in_use_r[i]) begin
        free_found = 1'b1;
        free_slot  = PW'(i);
      end
    end
    gen_inc = gen_r[free_slot] + 32'd1;
    if (gen_inc == 32'd0) begin
      gen_inc = 32'd1;
    end
  end

  // Sequencer: the next state, result and ring port.
  logic do_exec, do_write, do_read, do_close, do_create, do_retain, do_arm, do_cancel;
  logic wake_peer;

  always_comb begin
    state_nxt  = state_r;
    res_nxt    = res_r;
    strobe_nxt = 1'b0;
    q_pop      = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = AW'(own) * AW'(RING_DEPTH) + AW'(tail_r[own]);
    do_exec = 1'b0; do_write = 1'b0; do_read = 1'b0; do_close = 1'b0;
    do_create = 1'b0; do_retain = 1'b0; do_arm = 1'b0; do_cancel = 1'b0;
    wake_peer = 1'b0;
    case (state_r)
      ppct_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          state_nxt = ppct_pkg::BK_EXEC;
        end
      end
      ppct_pkg::BK_EXEC: begin
        do_exec   = 1'b1;
        res_nxt   = '0;
        res_nxt.last_echo = cur_r.last_in_transfer;
        state_nxt = ppct_pkg::BK_IDLE;
        strobe_nxt = 1'b1;
        if (cur_r.cmd == ppct_pkg::CMD_CREATE) begin
          if (!free_found) begin
            res_nxt.status = ppct_pkg::ST_NOSPACE;
          end else begin
            do_create = 1'b1;
            res_nxt.new_slot = 8'(free_slot);
            res_nxt.new_gen  = gen_inc;
          end
        end else if (!h_ok) begin
          res_nxt.status = ppct_pkg::ST_INVALID;
        end else begin
          case (cur_r.cmd)
            ppct_pkg::CMD_RETAIN: begin
              if (ref_r[own] == 32'hFFFF_FFFF) begin
                res_nxt.status = ppct_pkg::ST_INVALID;
              end else begin
                do_retain = 1'b1;
              end
            end
            ppct_pkg::CMD_CLOSE: begin
              do_close = 1'b1;
              if (ref_r[own] == 32'd1 && waiter_r[peer] != 64'd0) begin
                wake_peer          = 1'b1;
                res_nxt.wake_valid = 1'b1;
                res_nxt.wake_id    = waiter_r[peer];
              end
            end
            ppct_pkg::CMD_READ: begin
              if (fill_r[peer] != '0) begin
                do_read    = 1'b1;
                ram_addr   = AW'(peer) * AW'(RING_DEPTH) + AW'(head_r[peer]);
                strobe_nxt = 1'b0;
                state_nxt  = ppct_pkg::BK_RING;
              end else begin
                res_nxt.status = (ref_r[peer] == 32'd0) ? ppct_pkg::ST_HANGUP
                                                        : ppct_pkg::ST_BLOCK;
              end
            end
            ppct_pkg::CMD_WRITE: begin
              if (ref_r[peer] == 32'd0) begin
                res_nxt.status = ppct_pkg::ST_HANGUP;
              end else if (fill_r[own] == FW'(RING_DEPTH)) begin
                res_nxt.status = ppct_pkg::ST_BLOCK;
              end else begin
                do_write = 1'b1;
                ram_we   = 1'b1;
                if (waiter_r[peer] != 64'd0) begin
                  wake_peer          = 1'b1;
                  res_nxt.wake_valid = 1'b1;
                  res_nxt.wake_id    = waiter_r[peer];
                end
              end
            end
            ppct_pkg::CMD_POLL: begin
              res_nxt.readable  = (fill_r[peer] != '0);
              res_nxt.peer_gone = (ref_r[peer] == 32'd0);
            end
            ppct_pkg::CMD_ARM: begin
              if (cur_r.waiter_id == 64'd0) begin
                res_nxt.status = ppct_pkg::ST_INVALID;
              end else begin
                do_arm = 1'b1;
              end
            end
            ppct_pkg::CMD_CANCEL: begin
              do_cancel = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      ppct_pkg::BK_RING: begin
        res_nxt.read_byte = ram_rdata;
        strobe_nxt = 1'b1;
        state_nxt  = ppct_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = ppct_pkg::BK_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ppct_pkg::BK_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (q_pop) begin
      cur_r <= q_beat;
    end
  end

  // Pair table update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PAIRS; i++) begin
        in_use_r[i] <= 1'b0;
        gen_r[i]    <= 32'd0;
      end
      for (int k = 0; k < SIDES; k++) begin
        ref_r[k]    <= 32'd0;
        waiter_r[k] <= 64'd0;
        head_r[k]   <= '0;
        tail_r[k]   <= '0;
        fill_r[k]   <= '0;
      end
    end else if (do_exec) begin
      if (do_create) begin
        in_use_r[free_slot] <= 1'b1;
        gen_r[free_slot]    <= gen_inc;
        for (int s = 0; s < 2; s++) begin
          ref_r[SW'({free_slot, 1'b0}) | SW'(s)]    <= 32'd1;
          waiter_r[SW'({free_slot, 1'b0}) | SW'(s)] <= 64'd0;
          head_r[SW'({free_slot, 1'b0}) | SW'(s)]   <= '0;
          tail_r[SW'({free_slot, 1'b0}) | SW'(s)]   <= '0;
          fill_r[SW'({free_slot, 1'b0}) | SW'(s)]   <= '0;
        end
      end
      if (do_retain) begin
        ref_r[own] <= ref_r[own] + 32'd1;
      end
      if (do_close) begin
        ref_r[own] <= ref_r[own] - 32'd1;
        if (ref_r[own] == 32'd1) begin
          waiter_r[own] <= 64'd0;
          if (ref_r[peer] == 32'd0) begin
            in_use_r[slot] <= 1'b0;
          end
        end
      end
      if (wake_peer) begin
        waiter_r[peer] <= 64'd0;
      end
      // Ring pointers wrap at the ring depth.
      if (do_read) begin
        head_r[peer] <= (head_r[peer] == RW'(RING_DEPTH - 1)) ? '0
                                                              : head_r[peer] + RW'(1);
        fill_r[peer] <= fill_r[peer] - FW'(1);
      end
      if (do_write) begin
        tail_r[own] <= (tail_r[own] == RW'(RING_DEPTH - 1)) ? '0
                                                            : tail_r[own] + RW'(1);
        fill_r[own] <= fill_r[own] + FW'(1);
      end
      if (do_arm) begin
        waiter_r[own] <= cur_r.waiter_id;
      end
      if (do_cancel && waiter_r[own] == cur_r.waiter_id) begin
        waiter_r[own] <= 64'd0;
      end
    end
  end

  assign out_strobe = strobe_r;
  assign out_beat   = res_r;

endmodule

[hdl/pty_pair_channel_table.sv]
// A command passes the front end queue, the pop into cur_r and BK_EXEC before its
// result is registered; a successful byte read adds BK_RING for the registered read
// of the single ring memory port. The back end pops a new command only in BK_IDLE.
// Reset clears the pair table, counts, waiters and ring pointers at once.
// The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
// pty_pair_channel_table: channel pair table top level
// Command queue front end feeding the table execution back end.
// ----------------------------------------------------------------------------
module pty_pair_channel_table #(
  parameter int PAIRS      = 8,
  parameter int RING_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ppct_pkg::in_beat_t  in_beat,
  output logic                out_strobe,
  output ppct_pkg::out_beat_t out_beat
);

  logic               q_valid;
  logic               q_pop;
  ppct_pkg::in_beat_t q_beat;

  ppct_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_beat (in_beat),
    .q_valid (q_valid),
    .q_beat  (q_beat),
    .q_pop   (q_pop)
  );

  ppct_back #(.PAIRS(PAIRS), .RING_DEPTH(RING_DEPTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_beat     (q_beat),
    .q_pop      (q_pop),
    .out_strobe (out_strobe),
    .out_beat   (out_beat)
  );

endmodule

[bench/ppct_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppct_checker: result predictor and scoreboard for the channel pair table.
// Watches accepted command beats, models the pair table, rings, counts and
// waiters, and compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------
module ppct_checker #(
  parameter int PAIRS      = 8,
  parameter int RING_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  ppct_pkg::in_beat_t  in_beat,
  input  logic                out_strobe,
  input  ppct_pkg::out_beat_t out_beat,
  output int                  fail_count,
  output int                  pending
);

  localparam int SIDES = 2 * PAIRS;

  // Shadow copy of the table state.
  logic        used_q [PAIRS];
  logic [31:0] gen_q  [PAIRS];
  logic [31:0] refs_q [SIDES];
  logic [63:0] waiter_q [SIDES];
  logic [7:0]  ring_mem [SIDES][RING_DEPTH];
  int          head_q [SIDES];
  int          tail_q [SIDES];
  int          fill_q [SIDES];

  ppct_pkg::out_beat_t expected_results[$];

  // Computes the result of one command and updates the shadow state.
  function automatic ppct_pkg::out_beat_t table_step(ppct_pkg::in_beat_t b);
    ppct_pkg::out_beat_t r;
    int own;
    int peer;
    int slot;
    int k;
    bit ok;
    r = '0;
    r.last_echo = b.last_in_transfer;
    slot = int'(b.slot_index);
    own = 0;
    peer = 0;
    if (b.cmd == ppct_pkg::CMD_CREATE) begin
      k = -1;
      for (int i = PAIRS - 1; i >= 0; i--) if (!used_q[i]) k = i;
      if (k < 0) begin
        r.status = ppct_pkg::ST_NOSPACE;
      end else begin
        for (int s = 0; s < 2; s++) begin
          refs_q[k*2+s] = 32'd1;
          waiter_q[k*2+s] = '0;
          head_q[k*2+s] = 0;
          tail_q[k*2+s] = 0;
          fill_q[k*2+s] = 0;
        end
        gen_q[k] = gen_q[k] + 32'd1;
        if (gen_q[k] == 32'd0) gen_q[k] = 32'd1;
        used_q[k] = 1'b1;
        r.new_slot = k[7:0];
        r.new_gen = gen_q[k];
      end
      return r;
    end
    ok = (slot < PAIRS) && (b.handle_gen != 0);
    if (ok) ok = used_q[slot] && gen_q[slot] == b.handle_gen
                 && refs_q[slot*2+b.end_side] != 0;
    if (!ok) begin
      r.status = ppct_pkg::ST_INVALID;
      return r;
    end
    own = slot * 2 + b.end_side;
    peer = slot * 2 + (b.end_side ^ 1);
    case (ppct_pkg::cmd_t'(b.cmd))
      ppct_pkg::CMD_RETAIN: begin
        if (refs_q[own] == 32'hFFFF_FFFF) r.status = ppct_pkg::ST_INVALID;
        else refs_q[own]++;
      end
      ppct_pkg::CMD_CLOSE: begin
        refs_q[own]--;
        if (refs_q[own] == 0) begin
          waiter_q[own] = '0;
          if (waiter_q[peer] != 0) begin
            r.wake_valid = 1'b1;
            r.wake_id = waiter_q[peer];
            waiter_q[peer] = '0;
          end
          if (refs_q[peer] == 0) begin
            used_q[slot] = 1'b0;
            for (int s = 0; s < 2; s++) begin
              waiter_q[slot*2+s] = '0;
              head_q[slot*2+s] = 0;
              tail_q[slot*2+s] = 0;
              fill_q[slot*2+s] = 0;
            end
          end
        end
      end
      ppct_pkg::CMD_READ: begin
        if (fill_q[peer] != 0) begin
          r.read_byte = ring_mem[peer][head_q[peer]];
          head_q[peer] = (head_q[peer] + 1) % RING_DEPTH;
          fill_q[peer]--;
        end else begin
          r.status = (refs_q[peer] == 0) ? ppct_pkg::ST_HANGUP : ppct_pkg::ST_BLOCK;
        end
      end
      ppct_pkg::CMD_WRITE: begin
        if (refs_q[peer] == 0) begin
          r.status = ppct_pkg::ST_HANGUP;
        end else if (fill_q[own] >= RING_DEPTH) begin
          r.status = ppct_pkg::ST_BLOCK;
        end else begin
          ring_mem[own][tail_q[own]] = b.data_byte;
          tail_q[own] = (tail_q[own] + 1) % RING_DEPTH;
          fill_q[own]++;
          if (waiter_q[peer] != 0) begin
            r.wake_valid = 1'b1;
            r.wake_id = waiter_q[peer];
            waiter_q[peer] = '0;
          end
        end
      end
      ppct_pkg::CMD_POLL: begin
        r.readable = fill_q[peer] != 0;
        r.peer_gone = refs_q[peer] == 0;
      end
      ppct_pkg::CMD_ARM: begin
        if (b.waiter_id == 0) r.status = ppct_pkg::ST_INVALID;
        else waiter_q[own] = b.waiter_id;
      end
      default: begin
        if (waiter_q[own] == b.waiter_id) waiter_q[own] = '0;
      end
    endcase
    return r;
  endfunction

  // Predict on accepted command beats, compare on result beats.
  always @(posedge clk) begin
    ppct_pkg::out_beat_t want;
    if (!rst_n) begin
      fail_count <= 0;
      pending <= 0;
      expected_results.delete();
      for (int i = 0; i < PAIRS; i++) begin
        used_q[i] = 1'b0;
        gen_q[i] = '0;
      end
      for (int k = 0; k < SIDES; k++) begin
        refs_q[k] = '0;
        waiter_q[k] = '0;
        head_q[k] = 0;
        tail_q[k] = 0;
        fill_q[k] = 0;
      end
    end else begin
      if (out_strobe) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result beat %h", $time, out_beat);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_results.pop_front();
          if (want !== out_beat) begin
            $display("%0t: result mismatch expected %h actual %h", $time, want, out_beat);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy) expected_results.push_back(table_step(in_beat));
      pending <= expected_results.size();
    end
  end

endmodule

[bench/tb_pty_pair_channel_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pty_pair_channel_table: testbench for the channel pair table.
// Drives directed and random command beats with random gaps, mostly on live
// handles, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb_pty_pair_channel_table;

  localparam int PAIRS = 8;
  localparam int RING_DEPTH = 256;
  localparam int STALL_LIMIT = 2000;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  ppct_pkg::in_beat_t  in_beat;
  logic                out_strobe;
  ppct_pkg::out_beat_t out_beat;
  int                  fail_count;
  int                  pending;
  int                  idle_cycles;

  // Known live handles: slot and generation from create results.
  logic [7:0]  live_slot[$];
  logic [31:0] live_gen[$];

  pty_pair_channel_table #(.PAIRS(PAIRS), .RING_DEPTH(RING_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_strobe(out_strobe), .out_beat(out_beat)
  );

  ppct_checker #(.PAIRS(PAIRS), .RING_DEPTH(RING_DEPTH)) checker_i (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_strobe(out_strobe), .out_beat(out_beat), .fail_count(fail_count),
    .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Learn new handles from successful create results.
  always @(posedge clk) begin
    if (rst_n && out_strobe && out_beat.new_gen != 0) begin
      live_slot.push_back(out_beat.new_slot);
      live_gen.push_back(out_beat.new_gen);
    end
  end

  // Watchdog: counts cycles in which no beat moves.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Issue one command beat and wait until it is accepted. Start stays high
  // into the next beat when there is no gap.
  task automatic issue(input logic [2:0] op, input logic [7:0] slot, input logic side,
                       input logic [31:0] gen, input logic [7:0] data,
                       input logic [63:0] wid, input logic last, input bit gaps);
    int gap;
    gap = gaps ? ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11)) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_beat <= '{cmd: op, slot_index: slot, end_side: side, handle_gen: gen,
                 data_byte: data, waiter_id: wid, last_in_transfer: last};
    do @(posedge clk); while (busy);
  endtask

  // Random command, mostly on a live handle when one exists, else noise.
  task automatic random_command(input bit gaps);
    int pick;
    logic [7:0]  slot;
    logic [31:0] gen;
    logic [2:0]  op;
    logic [63:0] wid;
    pick = $urandom_range(0, 99);
    op = 3'($urandom_range(0, 7));
    wid = {$urandom, $urandom};
    if ($urandom_range(0, 3) == 0) wid = 64'($urandom_range(1, 3));
    if (live_slot.size() != 0 && pick < 85) begin
      pick = $urandom_range(0, live_slot.size() - 1);
      slot = live_slot[pick];
      gen = live_gen[pick];
      if (op == ppct_pkg::CMD_CREATE && $urandom_range(0, 1)) op = ppct_pkg::CMD_WRITE;
      if (op == ppct_pkg::CMD_CLOSE && $urandom_range(0, 2) != 0) op = ppct_pkg::CMD_READ;
    end else begin
      slot = ($urandom_range(0, 1)) ? 8'($urandom_range(0, PAIRS))
                                    : 8'($urandom_range(0, 255));
      gen = ($urandom_range(0, 1)) ? 32'($urandom_range(0, 4)) : $urandom;
    end
    issue(op, slot, 1'($urandom_range(0, 1)), gen, 8'($urandom_range(0, 255)), wid,
          1'($urandom_range(0, 1)), gaps);
    if (live_slot.size() > 12) begin
      live_slot.pop_front();
      live_gen.pop_front();
    end
  endtask

  initial begin
    int n;
    rst_n = 1'b0;
    start = 1'b0;
    in_beat = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: fill every slot, then overflow, then exercise one pair.
    for (int i = 0; i <= PAIRS; i++)
      issue(ppct_pkg::CMD_CREATE, 8'hFF, 1'b1, '1, 8'hFF, '1, 1'b1, 1'b0);
    issue(ppct_pkg::CMD_POLL, 8'hFF, 1'b0, 32'd1, 8'd0, '0, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_POLL, 8'd0, 1'b0, 32'd0, 8'd0, '0, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_POLL, 8'd0, 1'b0, 32'hFFFF_FFFF, 8'd0, '0, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_READ, 8'd0, 1'b1, 32'd1, 8'd0, '0, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_ARM, 8'd0, 1'b1, 32'd1, 8'd0, '0, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_ARM, 8'd0, 1'b1, 32'd1, 8'd0, '1, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_WRITE, 8'd0, 1'b0, 32'd1, 8'hA5, '0, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_WRITE, 8'd0, 1'b0, 32'd1, 8'h00, '0, 1'b1, 1'b0);
    issue(ppct_pkg::CMD_POLL, 8'd0, 1'b1, 32'd1, 8'd0, '0, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_READ, 8'd0, 1'b1, 32'd1, 8'd0, '0, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_READ, 8'd0, 1'b1, 32'd1, 8'd0, '0, 1'b1, 1'b0);
    issue(ppct_pkg::CMD_RETAIN, 8'd0, 1'b0, 32'd1, 8'd0, '0, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_ARM, 8'd0, 1'b0, 32'd1, 8'd0, 64'd7, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_CANCEL, 8'd0, 1'b0, 32'd1, 8'd0, 64'd8, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_ARM, 8'd0, 1'b1, 32'd1, 8'd0, 64'd9, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_CLOSE, 8'd0, 1'b1, 32'd1, 8'd0, '0, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_WRITE, 8'd0, 1'b0, 32'd1, 8'd1, '0, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_READ, 8'd0, 1'b0, 32'd1, 8'd0, '0, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_POLL, 8'd0, 1'b0, 32'd1, 8'd0, '0, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_CLOSE, 8'd0, 1'b0, 32'd1, 8'd0, '0, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_CLOSE, 8'd0, 1'b0, 32'd1, 8'd0, '0, 1'b0, 1'b0);
    issue(ppct_pkg::CMD_CREATE, 8'd0, 1'b0, 32'd0, 8'd0, '0, 1'b0, 1'b0);

    // Fill one ring to the top so a write would block.
    for (int i = 0; i < RING_DEPTH + 1; i++)
      issue(ppct_pkg::CMD_WRITE, 8'd1, 1'b0, 32'd1, 8'($urandom_range(0, 255)), '0,
            1'b0, i[0]);

    // Random part, with a burst of no gaps in the middle.
    for (n = 0; n < 110; n++) random_command(!(n >= 40 && n < 70));
    start <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
